>>> rtl/core/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared constants, codes and the arctangent table for the fractal
// value-noise pixel pipeline.
// ----------------------------------------------------------------------------
package fbm_pkg;

    // Texture edge length is a power of two; the coordinate divide is a shift.
    localparam int SIZE_LOG2   = 8;
    localparam int MAX_OCTAVES = 8;

    // Noise coordinate Q12.16 and lattice index width.
    localparam int COORD_W = 28;
    localparam int LAT_W   = 12;

    // Configuration register indices.
    localparam logic [1:0] CFG_NOISE_SCALE  = 2'd0;
    localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd1;
    localparam logic [1:0] CFG_MIN_LEVEL    = 2'd2;
    localparam logic [1:0] CFG_MAX_LEVEL    = 2'd3;

    // Lattice hash argument, reduced per axis modulo 2*pi in Q.24.
    localparam logic [22:0] HASH_X_MOD = 23'd7103966;    // 217932680 mod 2pi
    localparam logic [25:0] HASH_Y_MOD = 26'd47559655;   // 1312531939 mod 2pi
    localparam logic [26:0] TWO_PI     = 27'd105414357;
    // floor(2^50 / TWO_PI), used to estimate the quotient.
    localparam logic [23:0] TWO_PI_RECIP = 24'd10680707;

    localparam logic signed [32:0] PI_S      = 33'sd52707179;
    localparam logic signed [32:0] TWO_PI_S  = 33'sd105414357;
    localparam logic signed [32:0] HALF_PI_S = 33'sd26353589;

    localparam int CORDIC_STEPS = 20;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [31:0] HASH_MUL = 32'd2867760025;   // 43758.5453 in Q.16

    // Pipeline latencies in clock enables.
    localparam int HASH_LAT   = 7 + CORDIC_STEPS + 1;
    localparam int SMOOTH_DLY = HASH_LAT - 2;
    localparam int OCT_LAT    = HASH_LAT + 2;
    localparam int TOP_LAT    = OCT_LAT + 5;

    function automatic logic signed [32:0] atan_of(input int k);
        logic signed [32:0] a;
        case (k)
            0:  a = 33'sd843314857;
            1:  a = 33'sd497837829;
            2:  a = 33'sd263043837;
            3:  a = 33'sd133525159;
            4:  a = 33'sd67021687;
            5:  a = 33'sd33543516;
            6:  a = 33'sd16775851;
            7:  a = 33'sd8388437;
            8:  a = 33'sd4194283;
            9:  a = 33'sd2097149;
            10: a = 33'sd1048576;
            11: a = 33'sd524288;
            12: a = 33'sd262144;
            13: a = 33'sd131072;
            14: a = 33'sd65536;
            15: a = 33'sd32768;
            16: a = 33'sd16384;
            17: a = 33'sd8192;
            18: a = 33'sd4096;
            19: a = 33'sd2048;
            default: a = 33'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/fbm_value_noise_pixel.sv
// ----------------------------------------------------------------------------
// fbm_value_noise_pixel
// Fractal value-noise texture generator: one pixel coordinate in, one grey
// byte and its raster index out, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   i_pixel_x, i_pixel_y
//  output    out        o_out_valid / i_out_ready o_grey_level, o_pixel_index
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One beat is accepted every clock cycle while the output is not stalled; each
//  beat leaves once it has moved through the whole pipeline. The depth is set by
//  the lattice hash: argument reduction, twenty CORDIC stages and the fractional
//  multiply, followed by blending, octave summation and level mapping.
//  Reset is synchronous; it clears only the valid bits and loads the configuration defaults.
//  A stall on the output freezes every stage at once; no beat is lost or
//  repeated, and the input is taken again as soon as the output beat moves.
//
module fbm_value_noise_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_grey_level,
    output logic [15:0] o_pixel_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int NO  = fbm_pkg::MAX_OCTAVES;
    localparam int NP  = (NO + 1) / 2;
    localparam int LAT = fbm_pkg::TOP_LAT;
    localparam int CW  = fbm_pkg::COORD_W;

    // Configuration registers.
    logic [15:0] r_noise_scale;
    logic [3:0]  r_octave_count;
    logic [16:0] r_min_level;
    logic [16:0] r_max_level;

    // Valid bits and raster index travel alongside the data.
    logic        r_vld [LAT];
    logic [15:0] r_idx [LAT];

    logic        w_en;
    logic [39:0] w_nx_full, w_ny_full;
    logic [CW-1:0] r_nx, r_ny;
    logic [15:0] w_noise [NO];
    logic [31:0] w_term [NO];
    logic [31:0] r_pair [NP];
    logic [31:0] w_sum;
    logic [31:0] r_sum;
    logic [3:0]  w_oct;
    logic signed [17:0] w_diff;
    logic signed [50:0] r_map;
    logic signed [19:0] w_v;
    logic [16:0] w_vc;
    logic [24:0] w_g;
    logic [7:0]  r_grey;

    // The whole pipeline moves whenever the output register can take a beat.
    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_scale  <= 16'd1536;
            r_octave_count <= 4'd4;
            r_min_level    <= 17'd45875;
            r_max_level    <= 17'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbm_pkg::CFG_NOISE_SCALE:  r_noise_scale  <= i_cfg_data[15:0];
                fbm_pkg::CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                fbm_pkg::CFG_MIN_LEVEL:    r_min_level    <= i_cfg_data;
                fbm_pkg::CFG_MAX_LEVEL:    r_max_level    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage one: noise coordinates in Q12.16, i.e. pixel * scale / SIZE.
    assign w_nx_full = ((40'(i_pixel_x) * 40'(r_noise_scale)) << 8) >> fbm_pkg::SIZE_LOG2;
    assign w_ny_full = ((40'(i_pixel_y) * 40'(r_noise_scale)) << 8) >> fbm_pkg::SIZE_LOG2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx     <= w_nx_full[CW-1:0];
            r_ny     <= w_ny_full[CW-1:0];
            r_idx[0] <= 16'((32'(i_pixel_y) << fbm_pkg::SIZE_LOG2) + 32'(i_pixel_x));
            for (int k = 1; k < LAT; k++) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    // Each octave doubles the coordinate, wrapping on the lattice.
    for (genvar i = 0; i < NO; i++) begin : g_oct
        fbm_octave u_oct (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_cx    (CW'(r_nx << i)),
            .i_cy    (CW'(r_ny << i)),
            .o_noise (w_noise[i])
        );
    end

    // Octaves beyond the configured count contribute nothing; the count
    // saturates at the number of octave units.
    assign w_oct = (r_octave_count > 4'(NO)) ? 4'(NO) : r_octave_count;

    always_comb begin
        for (int i = 0; i < NO; i++) begin
            w_term[i] = (4'(i) < w_oct) ? (32'(w_noise[i]) << (15 - i)) : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NP; j++) begin
                r_pair[j] <= (2 * j + 1 < NO) ? w_term[2*j] + w_term[2*j+1] : w_term[2*j];
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < NP; j++) begin
            w_sum = w_sum + r_pair[j];
        end
    end

    // Level mapping: min + floor(sum * (max - min) / 2^32), then clamp and
    // scale to a byte.
    assign w_diff = $signed({1'b0, r_max_level}) - $signed({1'b0, r_min_level});
    assign w_v    = $signed({3'b0, r_min_level}) + 20'(r_map >>> 32);

    always_comb begin
        if (w_v < 0) begin
            w_vc = '0;
        end else if (w_v > 20'sd65536) begin
            w_vc = 17'd65536;
        end else begin
            w_vc = w_v[16:0];
        end
    end

    assign w_g = (25'(w_vc) << 8) - 25'(w_vc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum  <= w_sum;
            r_map  <= $signed({1'b0, r_sum}) * w_diff;
            r_grey <= w_g[23:16];
        end
    end

    assign o_out_valid   = r_vld[LAT-1];
    assign o_grey_level  = r_grey;
    assign o_pixel_index = r_idx[LAT-1];

    // A moving pipeline loads its first valid bit from the input handshake.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_load_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && !i_in_valid) |=> !r_vld[0])
        else $error("bubble entered the pipeline as a valid beat");

    // During a stall the waiting output beat keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_grey_level)
            && $stable(o_pixel_index)))
        else $error("output beat changed while stalled");

endmodule

>>> rtl/core/fbm_hash.sv
// ----------------------------------------------------------------------------
// fbm_hash
// Pipelined lattice hash: argument reduction modulo 2*pi, quadrant fold,
// one CORDIC rotation per stage and the final fractional multiply.
// ----------------------------------------------------------------------------
module fbm_hash (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fbm_pkg::LAT_W-1:0]   i_ix,
    input  logic [fbm_pkg::LAT_W-1:0]   i_iy,
    output logic [15:0]                 o_hash
);

    localparam int N = fbm_pkg::CORDIC_STEPS;

    logic [37:0] r_px, r_py, r_v;
    logic [27:0] r_v2, r_v3, r_qm, r_d;
    logic [11:0] r_q;
    logic [26:0] r_t;
    logic signed [32:0] r_z;
    logic signed [32:0] r_cx [N];
    logic signed [32:0] r_cy [N];
    logic signed [32:0] r_cz [N];
    logic signed [65:0] r_p;

    logic [47:0] w_qprod;
    logic signed [32:0] w_ts, w_tf;
    logic signed [32:0] w_x [N+1];
    logic signed [32:0] w_y [N+1];
    logic signed [32:0] w_z [N+1];

    assign w_qprod = 48'(r_v[37:14]) * 48'(fbm_pkg::TWO_PI_RECIP);

    always_comb begin
        w_ts = (r_t >= 27'(fbm_pkg::PI_S)) ? $signed({6'b0, r_t}) - fbm_pkg::TWO_PI_S
                                           : $signed({6'b0, r_t});
        if (w_ts > fbm_pkg::HALF_PI_S) begin
            w_tf = fbm_pkg::PI_S - w_ts;
        end else if (w_ts < -fbm_pkg::HALF_PI_S) begin
            w_tf = -fbm_pkg::PI_S - w_ts;
        end else begin
            w_tf = w_ts;
        end
    end

    // Reduction of the hash argument to a Q1.30 angle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= 38'(i_ix) * 38'(fbm_pkg::HASH_X_MOD);
            r_py <= 38'(i_iy) * 38'(fbm_pkg::HASH_Y_MOD);
            r_v  <= r_px + r_py;
            r_q  <= w_qprod[47:36];
            r_v2 <= r_v[27:0];
            r_qm <= 28'(40'(r_q) * 40'(fbm_pkg::TWO_PI));
            r_v3 <= r_v2;
            r_d  <= r_v3 - r_qm;
            r_t  <= (r_d >= 28'(fbm_pkg::TWO_PI)) ? 27'(r_d - 28'(fbm_pkg::TWO_PI))
                                                : r_d[26:0];
            r_z  <= w_tf <<< 6;
        end
    end

    assign w_x[0] = fbm_pkg::CORDIC_GAIN;
    assign w_y[0] = '0;
    assign w_z[0] = r_z;

    for (genvar k = 0; k < N; k++) begin : g_cordic
        assign w_x[k+1] = r_cx[k];
        assign w_y[k+1] = r_cy[k];
        assign w_z[k+1] = r_cz[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[k][32]) begin
                    r_cx[k] <= w_x[k] - (w_y[k] >>> k);
                    r_cy[k] <= w_y[k] + (w_x[k] >>> k);
                    r_cz[k] <= w_z[k] - fbm_pkg::atan_of(k);
                end else begin
                    r_cx[k] <= w_x[k] + (w_y[k] >>> k);
                    r_cy[k] <= w_y[k] - (w_x[k] >>> k);
                    r_cz[k] <= w_z[k] + fbm_pkg::atan_of(k);
                end
            end
        end
    end

    // The fraction is the low 46 bits of the two's complement product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_y[N] * $signed({1'b0, fbm_pkg::HASH_MUL});
        end
    end

    assign o_hash = r_p[45:30];

endmodule

>>> rtl/core/fbm_octave.sv
// ----------------------------------------------------------------------------
// fbm_octave
// One noise octave: four lattice hashes, smoothstep weights and two
// registered bilinear blend stages.
// ----------------------------------------------------------------------------
module fbm_octave (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fbm_pkg::COORD_W-1:0] i_cx,
    input  logic [fbm_pkg::COORD_W-1:0] i_cy,
    output logic [15:0]                 o_noise
);

    localparam int D = fbm_pkg::SMOOTH_DLY;

    logic [fbm_pkg::LAT_W-1:0] w_ix, w_iy, w_ix1, w_iy1;
    logic [15:0] w_h00, w_h10, w_h01, w_h11;
    logic [15:0] w_fx, w_fy;
    logic [49:0] w_px, w_py;

    logic [31:0] r_ffx, r_ffy;
    logic [17:0] r_kx, r_ky;
    logic [15:0] r_sx, r_sy;
    logic [15:0] r_sxd [D];
    logic [15:0] r_syd [D+1];
    logic [15:0] r_top, r_bot, r_noise;

    // a + floor((b - a) * t / 2^16) equals the two-product blend exactly.
    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] t);
        logic signed [16:0] d;
        logic signed [33:0] p;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, t});
        return 16'($signed({18'b0, a}) + (p >>> 16));
    endfunction

    assign w_ix  = i_cx[fbm_pkg::COORD_W-1:16];
    assign w_iy  = i_cy[fbm_pkg::COORD_W-1:16];
    assign w_ix1 = w_ix + 1'b1;
    assign w_iy1 = w_iy + 1'b1;
    assign w_fx  = i_cx[15:0];
    assign w_fy  = i_cy[15:0];

    fbm_hash u_h00 (.i_clk, .i_en, .i_ix(w_ix),  .i_iy(w_iy),  .o_hash(w_h00));
    fbm_hash u_h10 (.i_clk, .i_en, .i_ix(w_ix1), .i_iy(w_iy),  .o_hash(w_h10));
    fbm_hash u_h01 (.i_clk, .i_en, .i_ix(w_ix),  .i_iy(w_iy1), .o_hash(w_h01));
    fbm_hash u_h11 (.i_clk, .i_en, .i_ix(w_ix1), .i_iy(w_iy1), .o_hash(w_h11));

    assign w_px = 50'(r_ffx) * 50'(r_kx);
    assign w_py = 50'(r_ffy) * 50'(r_ky);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ffx <= 32'(w_fx) * 32'(w_fx);
            r_ffy <= 32'(w_fy) * 32'(w_fy);
            r_kx  <= 18'd196608 - 18'({w_fx, 1'b0});
            r_ky  <= 18'd196608 - 18'({w_fy, 1'b0});
            r_sx  <= w_px[47:32];
            r_sy  <= w_py[47:32];
            r_sxd[0] <= r_sx;
            r_syd[0] <= r_sy;
            for (int k = 1; k < D; k++) begin
                r_sxd[k] <= r_sxd[k-1];
            end
            for (int k = 1; k <= D; k++) begin
                r_syd[k] <= r_syd[k-1];
            end
            r_top   <= blend(w_h00, w_h10, r_sxd[D-1]);
            r_bot   <= blend(w_h01, w_h11, r_sxd[D-1]);
            r_noise <= blend(r_top, r_bot, r_syd[D]);
        end
    end

    assign o_noise = r_noise;

endmodule
